// ===== rtl/largest_clean_rectangle_macros.svh =====
// ----------------------------------------------------------------------------
// largest_clean_rectangle assertion macros
// Shared concurrent assertion wrappers for the rectangle search block.
// ----------------------------------------------------------------------------
`ifndef LARGEST_CLEAN_RECTANGLE_MACROS_SVH
`define LARGEST_CLEAN_RECTANGLE_MACROS_SVH

// checked outside reset only
`define LCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg
// Types and constants shared by the rectangle search block.
// ----------------------------------------------------------------------------
package lcr_pkg;

	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	localparam int CFG_W  = 11;
	localparam int AREA_W = 21;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	localparam logic [CFG_W-1:0]  COLS_RESET = 11'd1024;
	localparam logic [AREA_W-1:0] AREA_MAX   = {AREA_W{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_HGT,
		ST_CMP,
		ST_POP,
		ST_NEXT,
		ST_PUSH,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_PRE,
		PH_TILE,
		PH_POST
	} phase_t;

	typedef struct packed {
		logic note;
		logic clear;
	} area_ctl_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clear;
	} col_ctl_t;

	typedef struct packed {
		logic we;
		logic re;
	} stk_ctl_t;

endpackage

// ===== rtl/lcr_area_unit.sv =====
// ----------------------------------------------------------------------------
// lcr_area_unit
// Shared multiplier for bar area, saturation and running maximum.
// ----------------------------------------------------------------------------
module lcr_area_unit #(
	parameter int MAX_COLS = lcr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lcr_pkg::MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lcr_pkg::area_ctl_t        ctl,
	input  logic [$clog2(MAX_ROWS+1)-1:0] h,
	input  logic [$clog2(MAX_COLS+1)-1:0] span,
	output logic [lcr_pkg::AREA_W-1:0] best
);

	localparam int HW  = $clog2(MAX_ROWS + 1);
	localparam int PW  = $clog2(MAX_COLS + 1);
	localparam int PRW = HW + PW;
	localparam int EW  = (PRW > lcr_pkg::AREA_W) ? PRW : lcr_pkg::AREA_W;
	localparam logic [EW-1:0] LIM = EW'(lcr_pkg::AREA_MAX);

	logic [PRW-1:0]             prod_s1;
	logic                       pend_s1;
	logic [EW-1:0]              prod_x;
	logic [lcr_pkg::AREA_W-1:0] sat;
	logic [lcr_pkg::AREA_W-1:0] best_q;

	always_ff @(posedge clk) begin
		prod_s1 <= PRW'(h) * PRW'(span);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= ctl.note;
		end
	end

	assign prod_x = EW'(prod_s1);
	assign sat    = (prod_x > LIM) ? lcr_pkg::AREA_MAX : prod_x[lcr_pkg::AREA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctl.clear) begin
			best_q <= '0;
		end else if (pend_s1 && (sat > best_q)) begin
			best_q <= sat;
		end
	end

	assign best = best_q;

endmodule

// ===== rtl/lcr_col_heights.sv =====
// ----------------------------------------------------------------------------
// lcr_col_heights
// Per-column clean run memory with fill count and saturating update.
// ----------------------------------------------------------------------------
module lcr_col_heights #(
	parameter int MAX_COLS = lcr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lcr_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcr_pkg::col_ctl_t             ctl,
	input  logic [$clog2(MAX_COLS)-1:0]   addr,
	input  logic                          dirty,
	output logic [$clog2(MAX_ROWS+1)-1:0] h_new
);

	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int PW = $clog2(MAX_COLS + 1);

	logic [HW-1:0] mem [MAX_COLS];
	logic [HW-1:0] rd_q;
	logic          hit_q;
	logic [PW-1:0] fill_q;
	logic [PW-1:0] addr_x;
	logic [PW-1:0] addr_nx;
	logic [HW-1:0] h_old;

	assign addr_x  = PW'(addr);
	assign addr_nx = PW'(addr_x + 1'b1);

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q  <= mem[addr];
			hit_q <= addr_x < fill_q;
		end
		if (ctl.wr) begin
			mem[addr] <= h_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.wr && (addr_nx > fill_q)) begin
			fill_q <= addr_nx;
		end
	end

	assign h_old = hit_q ? rd_q : '0;

	always_comb begin
		if (dirty) begin
			h_new = '0;
		end else if (h_old < HW'(MAX_ROWS)) begin
			h_new = HW'(h_old + 1'b1);
		end else begin
			h_new = HW'(MAX_ROWS);
		end
	end

endmodule

// ===== rtl/lcr_stack_ram.sv =====
// ----------------------------------------------------------------------------
// lcr_stack_ram
// Bar stack storage: height and start position, registered read.
// ----------------------------------------------------------------------------
module lcr_stack_ram #(
	parameter int MAX_COLS = lcr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lcr_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  lcr_pkg::stk_ctl_t             ctl,
	input  logic [$clog2(MAX_COLS+1)-1:0] waddr,
	input  logic [$clog2(MAX_ROWS+1)-1:0] wh,
	input  logic [$clog2(MAX_COLS+1)-1:0] ws,
	input  logic [$clog2(MAX_COLS+1)-1:0] raddr,
	output logic [$clog2(MAX_ROWS+1)-1:0] rh,
	output logic [$clog2(MAX_COLS+1)-1:0] rs
);

	localparam int HW  = $clog2(MAX_ROWS + 1);
	localparam int PW  = $clog2(MAX_COLS + 1);
	localparam int CAP = MAX_COLS + 1;

	logic [HW-1:0] mem_h [CAP];
	logic [PW-1:0] mem_s [CAP];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_h[waddr] <= wh;
			mem_s[waddr] <= ws;
		end
		if (ctl.re) begin
			rh <= mem_h[raddr];
			rs <= mem_s[raddr];
		end
	end

endmodule

// ===== rtl/largest_clean_rectangle.sv =====
// ----------------------------------------------------------------------------
// largest_clean_rectangle: largest all-clean rectangle over a streamed grid
// Per tile: height read and update, compare, pops, push (none on an equal bar); not ready meanwhile.
// A row end or a width-change flush pops every bar; after a final tile the result is loaded.
// One area multiplier, one stack memory with separate read and write ports.
// Async reset clears control state; no clearing pass, heights use a fill count.
// ----------------------------------------------------------------------------
`include "largest_clean_rectangle_macros.svh"

module largest_clean_rectangle #(
	parameter int MAX_COLS = lcr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lcr_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lcr_pkg::IN_TDATA_W-1:0]  s_tdata,  // [0] dirty, rest zero
	input  logic                            s_tlast,  // last_tile
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lcr_pkg::OUT_TDATA_W-1:0] m_tdata,  // [20:0] clean_area, rest zero
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcr_pkg::CFG_W-1:0]       cfg_data  // columns
);

	localparam int HW  = $clog2(MAX_ROWS + 1);
	localparam int PW  = $clog2(MAX_COLS + 1);
	localparam int AW  = $clog2(MAX_COLS);
	localparam int CAP = MAX_COLS + 1;
	localparam int DW  = $clog2(CAP + 1);
	localparam int CW  = (lcr_pkg::CFG_W > PW + 1) ? lcr_pkg::CFG_W : PW + 1;

	lcr_pkg::state_t state_q, state_d;
	lcr_pkg::phase_t phase_q;

	logic [lcr_pkg::CFG_W-1:0]  columns_q;
	logic                       dirty_q;
	logic                       last_q;
	logic [PW-1:0]              pos_q;
	logic [PW-1:0]              col_q;
	logic [HW-1:0]              cur_h_q;
	logic [PW-1:0]              cur_p_q;
	logic [PW-1:0]              start_q;
	logic [HW-1:0]              top_h_q;
	logic [PW-1:0]              top_s_q;
	logic [DW-1:0]              depth_q;
	logic [lcr_pkg::AREA_W-1:0] res_q;
	logic                       m_valid_q;

	logic [CW-1:0]              cols_x;
	logic [PW-1:0]              eff;
	logic [PW-1:0]              col_nx;
	logic                       row_end;
	logic [PW-1:0]              span;
	logic                       s_acc;
	logic                       out_load;
	logic [HW-1:0]              h_new;
	logic [HW-1:0]              rd_h;
	logic [PW-1:0]              rd_s;
	logic [lcr_pkg::AREA_W-1:0] best;
	lcr_pkg::area_ctl_t         area_ctl;
	lcr_pkg::col_ctl_t          col_ctl;
	lcr_pkg::stk_ctl_t          stk_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= lcr_pkg::COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			columns_q <= cfg_data;
		end
	end

	assign cols_x = CW'(columns_q);

	always_comb begin
		if (cols_x == '0) begin
			eff = PW'(1);
		end else if (cols_x > CW'(MAX_COLS)) begin
			eff = PW'(MAX_COLS);
		end else begin
			eff = PW'(cols_x);
		end
	end

	assign col_nx   = PW'(col_q + 1'b1);
	assign row_end  = (col_nx >= eff) || last_q;
	assign span     = (cur_p_q >= top_s_q) ? PW'(cur_p_q - top_s_q) : '0;
	assign s_acc    = s_tvalid && s_tready;
	assign out_load = (state_q == lcr_pkg::ST_OUT) && (!m_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcr_pkg::ST_IDLE: begin
				if (s_acc) begin
					state_d = (pos_q >= eff) ? lcr_pkg::ST_CMP : lcr_pkg::ST_RD;
				end
			end
			lcr_pkg::ST_RD:   state_d = lcr_pkg::ST_HGT;
			lcr_pkg::ST_HGT:  state_d = lcr_pkg::ST_CMP;
			lcr_pkg::ST_CMP: begin
				if (depth_q == '0 || top_h_q < cur_h_q) begin
					state_d = lcr_pkg::ST_PUSH;
				end else if (top_h_q == cur_h_q) begin
					state_d = lcr_pkg::ST_DONE;
				end else begin
					state_d = lcr_pkg::ST_POP;
				end
			end
			lcr_pkg::ST_POP:  state_d = lcr_pkg::ST_NEXT;
			lcr_pkg::ST_NEXT: begin
				if (depth_q != '0 && rd_h >= cur_h_q) begin
					state_d = lcr_pkg::ST_POP;
				end else begin
					state_d = lcr_pkg::ST_PUSH;
				end
			end
			lcr_pkg::ST_PUSH: state_d = lcr_pkg::ST_DONE;
			lcr_pkg::ST_DONE: begin
				unique case (phase_q)
					lcr_pkg::PH_PRE:  state_d = lcr_pkg::ST_RD;
					lcr_pkg::PH_TILE: state_d = row_end ? lcr_pkg::ST_CMP : lcr_pkg::ST_IDLE;
					lcr_pkg::PH_POST: state_d = last_q ? lcr_pkg::ST_OUT : lcr_pkg::ST_IDLE;
					default:          state_d = lcr_pkg::ST_IDLE;
				endcase
			end
			lcr_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = lcr_pkg::ST_IDLE;
				end
			end
			default: state_d = lcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = state_q == lcr_pkg::ST_IDLE;
		col_ctl.rd     = state_q == lcr_pkg::ST_RD;
		col_ctl.wr     = state_q == lcr_pkg::ST_HGT;
		col_ctl.clear  = out_load;
		area_ctl.note  = state_q == lcr_pkg::ST_POP;
		area_ctl.clear = out_load;
		stk_ctl.re     = (state_q == lcr_pkg::ST_POP) && (depth_q >= DW'(2));
		stk_ctl.we     = (state_q == lcr_pkg::ST_PUSH) && (phase_q == lcr_pkg::PH_TILE)
			&& (depth_q < DW'(CAP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lcr_pkg::ST_IDLE;
			phase_q   <= lcr_pkg::PH_TILE;
			pos_q     <= '0;
			depth_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				lcr_pkg::ST_IDLE: begin
					if (s_acc) begin
						phase_q <= (pos_q >= eff) ? lcr_pkg::PH_PRE : lcr_pkg::PH_TILE;
					end
				end
				lcr_pkg::ST_POP: begin
					depth_q <= DW'(depth_q - 1'b1);
				end
				lcr_pkg::ST_PUSH: begin
					if (stk_ctl.we) begin
						depth_q <= DW'(depth_q + 1'b1);
					end
				end
				lcr_pkg::ST_DONE: begin
					unique case (phase_q)
						lcr_pkg::PH_PRE: begin
							depth_q <= '0;
							pos_q   <= '0;
							phase_q <= lcr_pkg::PH_TILE;
						end
						lcr_pkg::PH_TILE: begin
							pos_q <= col_nx;
							if (row_end) begin
								phase_q <= lcr_pkg::PH_POST;
							end
						end
						lcr_pkg::PH_POST: begin
							depth_q <= '0;
							pos_q   <= '0;
						end
						default: phase_q <= lcr_pkg::PH_TILE;
					endcase
				end
				lcr_pkg::ST_OUT: begin
					if (out_load) begin
						phase_q <= lcr_pkg::PH_TILE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lcr_pkg::ST_IDLE: begin
				if (s_acc) begin
					dirty_q <= s_tdata[0];
					last_q  <= s_tlast;
					col_q   <= pos_q;
					cur_h_q <= '0;
					cur_p_q <= pos_q;
				end
			end
			lcr_pkg::ST_HGT: begin
				cur_h_q <= h_new;
				cur_p_q <= col_q;
			end
			lcr_pkg::ST_CMP: begin
				start_q <= cur_p_q;
			end
			lcr_pkg::ST_POP: begin
				start_q <= top_s_q;
			end
			lcr_pkg::ST_NEXT: begin
				if (depth_q != '0) begin
					top_h_q <= rd_h;
					top_s_q <= rd_s;
				end
			end
			lcr_pkg::ST_PUSH: begin
				if (stk_ctl.we) begin
					top_h_q <= cur_h_q;
					top_s_q <= start_q;
				end
			end
			lcr_pkg::ST_DONE: begin
				if (phase_q == lcr_pkg::PH_PRE) begin
					col_q <= '0;
				end else if (phase_q == lcr_pkg::PH_TILE) begin
					cur_h_q <= '0;
					cur_p_q <= col_nx;
				end
			end
			lcr_pkg::ST_OUT: begin
				if (out_load) begin
					res_q <= best;
				end
			end
			default: ;
		endcase
	end

	lcr_col_heights #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_heights (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (col_ctl),
		.addr   (col_q[AW-1:0]),
		.dirty  (dirty_q),
		.h_new  (h_new)
	);

	lcr_stack_ram #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_stack (
		.clk   (clk),
		.ctl   (stk_ctl),
		.waddr (PW'(depth_q)),
		.wh    (cur_h_q),
		.ws    (start_q),
		.raddr (PW'(depth_q - DW'(2))),
		.rh    (rd_h),
		.rs    (rd_s)
	);

	lcr_area_unit #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (area_ctl),
		.h      (top_h_q),
		.span   (span),
		.best   (best)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = lcr_pkg::OUT_TDATA_W'(res_q);

	`LCR_ASSERT_ALWAYS(a_depth_cap, clk, !arst_n || depth_q <= DW'(CAP), "stack depth over capacity")
	`LCR_ASSERT(a_busy_after_req, clk, arst_n, s_acc |=> !s_tready, "ready right after request")
	`LCR_ASSERT(a_pop_nonempty, clk, arst_n, state_q == lcr_pkg::ST_POP |-> depth_q != '0, "empty pop")
	`LCR_ASSERT(a_out_loaded, clk, arst_n, out_load |=> m_tvalid, "result load lost")

endmodule
